/* rtl/core/wfcd_pkg.sv */
// shared types, constants and the bytewise crc-8 step for the weather frame decoder
// used by every module under rtl/core; depends on nothing
package wfcd_pkg;

    localparam int FRAME_LEN   = 15;
    localparam int COUNT_MAX   = 16;
    localparam int CAP_DEPTH   = 10;
    localparam int COUNT_W     = 5;
    localparam int OUT_DATA_W  = 72;

    localparam logic [7:0]  MARKER      = 8'hd4;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'h00;
    localparam logic [3:0]  NIBBLE_MASK = 4'hf;
    localparam logic [12:0] TEMP_OFFSET = 13'd400;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LENGTH = 2'd1,
        STATUS_MARKER = 2'd2,
        STATUS_CRC    = 2'd3
    } status_t;

    // frame checks and captured bytes handed from the tracker to the decoder
    typedef struct packed {
        logic                          len_ok;
        logic                          marker_ok;
        logic                          crc_ok;
        logic [CAP_DEPTH-1:0][7:0]     captures;
    } frame_info_t;

    // first field sits in the highest bits
    typedef struct packed {
        logic [7:0]         humidity_percent;
        logic signed [12:0] temperature_tenths;
        logic [11:0]        rain_total;
        logic [8:0]         wind_direction;
        logic [8:0]         wind_gust;
        logic [8:0]         wind_average;
        logic               batt_good;
        logic [7:0]         sensor_id;
        status_t            status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // msb-first crc-8, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/wfcd_tracker.sv */
// per-frame state: saturating byte count, running crc, marker flag and byte captures
// depends on wfcd_pkg
module wfcd_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output wfcd_pkg::frame_info_t info
);

    logic [wfcd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   crc_reg, crc_next, crc_step;
    logic                         marker_reg, marker_next;
    logic [wfcd_pkg::CAP_DEPTH-1:0][7:0] cap_reg, cap_next;
    logic                         in_frame;

    assign in_frame = (count_reg < wfcd_pkg::COUNT_W'(wfcd_pkg::FRAME_LEN));
    assign crc_step = in_frame ? wfcd_pkg::crc8_step(crc_reg, data_byte) : crc_reg;

    always_comb begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        marker_next = marker_reg;
        cap_next    = cap_reg;
        if (accept) begin
            if (in_frame) begin
                crc_next = crc_step;
                if (count_reg == '0) begin
                    marker_next = (data_byte == wfcd_pkg::MARKER);
                end
            end
            for (int k = 0; k < wfcd_pkg::CAP_DEPTH; k++) begin
                if (count_reg == wfcd_pkg::COUNT_W'(k + 1)) begin
                    cap_next[k] = data_byte;
                end
            end
            if (count_reg < wfcd_pkg::COUNT_W'(wfcd_pkg::COUNT_MAX)) begin
                count_next = count_reg + 1'b1;
            end
            if (last_byte) begin
                count_next  = '0;
                crc_next    = wfcd_pkg::CRC_INIT;
                marker_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            crc_reg    <= wfcd_pkg::CRC_INIT;
            marker_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            marker_reg <= marker_next;
        end
    end

    // captures carry no reset
    always_ff @(posedge aclk) begin
        cap_reg <= cap_next;
    end

    // checks as seen with the current byte included; a good length means this
    // byte is the fifteenth, so marker and captures are already settled
    always_comb begin
        info.len_ok    = (count_reg == wfcd_pkg::COUNT_W'(wfcd_pkg::FRAME_LEN - 1));
        info.marker_ok = marker_reg;
        info.crc_ok    = (crc_step == 8'h00);
        info.captures  = cap_reg;
    end

endmodule

/* rtl/core/wfcd_decode.sv */
// frame check priority and sensor field unpacking
// depends on wfcd_pkg
module wfcd_decode (
    input  wfcd_pkg::frame_info_t info,
    output wfcd_pkg::result_t     result
);

    logic [11:0] temp_code;

    assign temp_code = {info.captures[7][3:0] & wfcd_pkg::NIBBLE_MASK, info.captures[8]};

    always_comb begin
        result = '0;
        priority if (!info.len_ok) begin
            result.status = wfcd_pkg::STATUS_LENGTH;
        end else if (!info.marker_ok) begin
            result.status = wfcd_pkg::STATUS_MARKER;
        end else if (!info.crc_ok) begin
            result.status = wfcd_pkg::STATUS_CRC;
        end else begin
            result.status             = wfcd_pkg::STATUS_OK;
            result.sensor_id          = info.captures[0];
            result.batt_good          = ~info.captures[1][3];
            result.wind_average       = {info.captures[1][0], info.captures[2]};
            result.wind_gust          = {info.captures[1][1], info.captures[3]};
            result.wind_direction     = {info.captures[1][2], info.captures[4]};
            result.rain_total         = {info.captures[5][3:0] & wfcd_pkg::NIBBLE_MASK,
                                         info.captures[6]};
            result.temperature_tenths = $signed({1'b0, temp_code} - wfcd_pkg::TEMP_OFFSET);
            result.humidity_percent   = info.captures[9];
        end
    end

endmodule

/* rtl/core/wfcd_out_buf.sv */
// two-entry result buffer (output register plus skid register)
// depends on wfcd_pkg
module wfcd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wfcd_pkg::result_t push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output wfcd_pkg::result_t m_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    wfcd_pkg::result_t main_data_reg, main_data_next;
    wfcd_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop   = main_valid_reg && m_ready;
    assign space = !skid_valid_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

endmodule

/* rtl/core/weather_frame_crc_field_decoder.sv */
// weather sensor frame decoder: crc-8 checked, 15-byte frames, one byte per request
// a finished frame's result goes to the output register, or to the skid register
// throughput: one byte per cycle; s_tready drops only when two results wait unread
// reset (aresetn low, synchronous) clears byte count, crc, marker flag and result
// buffer; the byte captures are not reset
module weather_frame_crc_field_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], sensor_id[9:2], batt_good[10], wind_average[19:11],
    // wind_gust[28:20], wind_direction[37:29], rain_total[49:38],
    // temperature_tenths[62:50], humidity_percent[70:63], zero[71]
    output logic [wfcd_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic                  accept;
    logic                  space;
    wfcd_pkg::frame_info_t info;
    wfcd_pkg::result_t     result;
    wfcd_pkg::result_t     out_data;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    wfcd_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .info      (info)
    );

    wfcd_decode u_decode (
        .info   (info),
        .result (result)
    );

    wfcd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && s_tlast),
        .push_data (result),
        .space     (space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {(wfcd_pkg::OUT_DATA_W - wfcd_pkg::RESULT_W)'(0), out_data};

endmodule
